### src/bsp_hull_axis_move_assert.svh
// Assertion macros used by the checker file.
`ifndef BSP_HULL_AXIS_MOVE_ASSERT_SVH
`define BSP_HULL_AXIS_MOVE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BHM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define BHM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### src/bhm_pkg.sv
// Shared types and constants for the axis move block.
`timescale 1ns / 1ps
package bhm_pkg;
  localparam int unsigned NodeDepth    = 4096;
  localparam int unsigned PlaneDepth   = 4096;
  localparam int unsigned MaxWalkSteps = 4096;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned InDataW      = 256;
  localparam int unsigned OutDataW     = 104;

  localparam logic [1:0] CmdNode  = 2'd0;
  localparam logic [1:0] CmdPlane = 2'd1;
  localparam logic [1:0] CmdMove  = 2'd2;
  localparam logic [1:0] CmdSpare = 2'd3;

  localparam logic [1:0] CfgHullOne = 2'd0;
  localparam logic [1:0] CfgHullTwo = 2'd1;
  localparam logic [1:0] CfgNodes   = 2'd2;
  localparam logic [1:0] CfgPlanes  = 2'd3;

  localparam logic signed [17:0] NormMax = 18'sd131071;
  localparam logic signed [17:0] NormMin = -18'sd131072;
  localparam logic signed [15:0] SolidLeaf = -16'sd2;

  // Item passed from front to back through the queue.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        entry_index;
    logic [11:0]        plane_ref;
    logic signed [15:0] child_negative;
    logic signed [15:0] child_positive;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] aux_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               hull_two;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               on_ground;
    logic               walk_fault;
  } result_t;

  function automatic logic signed [17:0] sat_norm(input logic signed [31:0] v);
    logic signed [17:0] r;
    if (v > 32'(NormMax)) r = NormMax;
    else if (v < 32'(NormMin)) r = NormMin;
    else r = v[17:0];
    return r;
  endfunction
endpackage

### src/bsp_hull_axis_move.sv
// Top level of the axis move block.
`timescale 1ns / 1ps
// Collision-aware move against a clipnode tree. Items enter on s_axis; cmd in tuser
// selects node write, plane write or move. The back end takes writes while idle. A
// move tries X, Y, Z; each changed axis walks the tree one node at a time (node read
// and check, plane read and wait, one multiply stage, sum, branch), and each walk is
// bounded by the step limit. One move runs at a time; a four-entry queue buffers items
// ahead of it, and the result register holds one answer while the next item is taken in.
module bsp_hull_axis_move #(
  parameter int unsigned NODE_DEPTH     = bhm_pkg::NodeDepth,
  parameter int unsigned PLANE_DEPTH    = bhm_pkg::PlaneDepth,
  parameter int unsigned MAX_WALK_STEPS = bhm_pkg::MaxWalkSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, plane_ref, child_negative, child_positive, vec_x, vec_y, vec_z,
  // aux_x, target_y, target_z, hull_select
  input  logic [bhm_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, on_ground, walk_fault
  output logic [bhm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i
);
  logic signed [12:0] hull_one_q, hull_two_q;
  logic [12:0]        nodes_q, planes_q;
  logic               item_valid, item_ready;
  bhm_pkg::item_t     item;
  bhm_pkg::result_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hull_one_q <= -13'sd1;
      hull_two_q <= -13'sd1;
      nodes_q <= '0;
      planes_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bhm_pkg::CfgHullOne: hull_one_q <= cfg_data_i;
        bhm_pkg::CfgHullTwo: hull_two_q <= cfg_data_i;
        bhm_pkg::CfgNodes:   nodes_q <= cfg_data_i;
        bhm_pkg::CfgPlanes:  planes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bhm_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  bhm_back #(
    .NodeDepth(NODE_DEPTH), .PlaneDepth(PLANE_DEPTH), .MaxWalkSteps(MAX_WALK_STEPS)
  ) u_back (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item),
    .hull_one_root_i(hull_one_q), .hull_two_root_i(hull_two_q),
    .nodes_in_use_i(nodes_q), .planes_in_use_i(planes_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.walk_fault, res.on_ground, res.pos_z, res.pos_y,
                         res.pos_x};
endmodule

### src/bhm_front.sv
// Front end: unpacks beats, drops unknown commands and queues items.
`timescale 1ns / 1ps
module bhm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bhm_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output bhm_pkg::item_t               item_o
);
  localparam int unsigned QueueDepth = bhm_pkg::QueueDepth;
  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  bhm_pkg::item_t     mem_q [QueueDepth];
  logic [AW-1:0]      wr_q, rd_q;
  logic [AW:0]        cnt_q;
  bhm_pkg::item_t     in_item;
  logic               push, pop;

  always_comb begin
    in_item.cmd            = s_axis_tuser;
    in_item.entry_index    = s_axis_tdata[11:0];
    in_item.plane_ref      = s_axis_tdata[23:12];
    in_item.child_negative = s_axis_tdata[39:24];
    in_item.child_positive = s_axis_tdata[55:40];
    in_item.vec_x          = s_axis_tdata[87:56];
    in_item.vec_y          = s_axis_tdata[119:88];
    in_item.vec_z          = s_axis_tdata[151:120];
    in_item.aux_x          = s_axis_tdata[183:152];
    in_item.target_y       = s_axis_tdata[215:184];
    in_item.target_z       = s_axis_tdata[247:216];
    in_item.hull_two       = (s_axis_tdata[249:248] == 2'd2);
  end

  assign s_axis_tready = (cnt_q != (AW+1)'(QueueDepth));
  // Unknown command: drop at the door.
  assign push = s_axis_tvalid && s_axis_tready && (s_axis_tuser != bhm_pkg::CmdSpare);
  assign item_valid_o = (cnt_q != '0);
  assign pop = item_valid_o && item_ready_i;
  assign item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == AW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### src/bhm_back.sv
// Back end: table writes and the three axis trials with a tree walker.
`timescale 1ns / 1ps
module bhm_back #(
  parameter int unsigned NodeDepth    = bhm_pkg::NodeDepth,
  parameter int unsigned PlaneDepth   = bhm_pkg::PlaneDepth,
  parameter int unsigned MaxWalkSteps = bhm_pkg::MaxWalkSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  bhm_pkg::item_t      item_i,
  input  logic signed [12:0]  hull_one_root_i,
  input  logic signed [12:0]  hull_two_root_i,
  input  logic [12:0]         nodes_in_use_i,
  input  logic [12:0]         planes_in_use_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output bhm_pkg::result_t    res_o
);
  localparam int unsigned NAW = $clog2(NodeDepth);
  localparam int unsigned PAW = $clog2(PlaneDepth);
  localparam int unsigned SW  = $clog2(MaxWalkSteps + 1);

  typedef enum logic [3:0] {
    StIdle, StAxis, StNodeRd, StNodeWt, StPlaneRd, StPlaneWt, StMul, StSum, StNext, StOut
  } state_e;

  logic [43:0] node_mem   [NodeDepth];
  logic [53:0] normal_mem [PlaneDepth];
  logic [31:0] dist_mem   [PlaneDepth];

  state_e              state_q;
  logic [1:0]          axis_q;
  logic signed [31:0]  cur_q [3];
  logic signed [31:0]  tgt_q [3];
  logic signed [31:0]  pt_q  [3];
  logic signed [15:0]  idx_q;
  logic [SW-1:0]       steps_q;
  logic signed [12:0]  root_q;
  logic                fault_q, ground_q;
  logic [43:0]         node_rd_q;
  logic [53:0]         norm_rd_q;
  logic [31:0]         dist_rd_q;
  logic signed [49:0]  prod_q [3];
  logic signed [47:0]  dsh_q;
  logic                res_valid_q;
  bhm_pkg::result_t    res_q;
  logic signed [52:0]  dsum;
  logic [11:0]         plane_idx;

  assign item_ready_o = (state_q == StIdle);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;
  assign plane_idx    = node_rd_q[43:32];
  assign dsum = 53'(prod_q[0]) + 53'(prod_q[1]) + 53'(prod_q[2]) - 53'(dsh_q);

  // Table writes; depth check drops out-of-range indices.
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      if (item_i.cmd == bhm_pkg::CmdNode && 32'(item_i.entry_index) < NodeDepth)
        node_mem[item_i.entry_index[NAW-1:0]] <=
          {item_i.plane_ref, item_i.child_negative, item_i.child_positive};
      if (item_i.cmd == bhm_pkg::CmdPlane && 32'(item_i.entry_index) < PlaneDepth) begin
        normal_mem[item_i.entry_index[PAW-1:0]] <= {bhm_pkg::sat_norm(item_i.vec_x),
          bhm_pkg::sat_norm(item_i.vec_y), bhm_pkg::sat_norm(item_i.vec_z)};
        dist_mem[item_i.entry_index[PAW-1:0]] <= item_i.aux_x;
      end
    end
    if (state_q == StNodeRd) node_rd_q <= node_mem[idx_q[NAW-1:0]];
    if (state_q == StPlaneRd) begin
      norm_rd_q <= normal_mem[plane_idx[PAW-1:0]];
      dist_rd_q <= dist_mem[plane_idx[PAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_valid_q <= 1'b0;
      axis_q <= '0;
      idx_q <= '0;
      steps_q <= '0;
      fault_q <= 1'b0;
      ground_q <= 1'b0;
      root_q <= '0;
      res_q <= '0;
      dsh_q <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0; tgt_q[i] <= '0; pt_q[i] <= '0; prod_q[i] <= '0;
      end
    end else begin
      // StOut reloads the result register itself when it drains.
      if (res_valid_q && res_ready_i && state_q != StOut) res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (item_valid_i && item_ready_o && item_i.cmd == bhm_pkg::CmdMove) begin
            cur_q[0] <= item_i.vec_x; cur_q[1] <= item_i.vec_y; cur_q[2] <= item_i.vec_z;
            tgt_q[0] <= item_i.aux_x; tgt_q[1] <= item_i.target_y;
            tgt_q[2] <= item_i.target_z;
            root_q <= item_i.hull_two ? hull_two_root_i : hull_one_root_i;
            axis_q <= '0;
            fault_q <= 1'b0;
            ground_q <= 1'b0;
            state_q <= StAxis;
          end
        end
        StAxis: begin
          if (axis_q == 2'd3) begin
            state_q <= StOut;
          end else if (tgt_q[axis_q] == cur_q[axis_q]) begin
            axis_q <= axis_q + 2'd1;
          end else if (root_q < 0) begin
            fault_q <= 1'b1;
            cur_q[axis_q] <= tgt_q[axis_q];
            axis_q <= axis_q + 2'd1;
          end else begin
            for (int i = 0; i < 3; i++)
              pt_q[i] <= (i == int'(axis_q)) ? tgt_q[i] : cur_q[i];
            idx_q <= 16'(root_q);
            steps_q <= '0;
            state_q <= StNodeRd;
          end
        end
        StNodeRd: begin
          if (32'(steps_q) >= MaxWalkSteps || 16'(idx_q) >= 16'(nodes_in_use_i)
              || 32'(idx_q) >= NodeDepth) begin
            fault_q <= 1'b1;
            cur_q[axis_q] <= tgt_q[axis_q];
            axis_q <= axis_q + 2'd1;
            state_q <= StAxis;
          end else begin
            steps_q <= steps_q + 1'b1;
            state_q <= StNodeWt;
          end
        end
        StNodeWt: begin
          if (13'(plane_idx) >= planes_in_use_i || 32'(plane_idx) >= PlaneDepth) begin
            fault_q <= 1'b1;
            cur_q[axis_q] <= tgt_q[axis_q];
            axis_q <= axis_q + 2'd1;
            state_q <= StAxis;
          end else begin
            state_q <= StPlaneRd;
          end
        end
        StPlaneRd: state_q <= StPlaneWt;
        StPlaneWt: state_q <= StMul;
        StMul: begin
          prod_q[0] <= $signed(norm_rd_q[53:36]) * pt_q[0];
          prod_q[1] <= $signed(norm_rd_q[35:18]) * pt_q[1];
          prod_q[2] <= $signed(norm_rd_q[17:0]) * pt_q[2];
          dsh_q <= {$signed(dist_rd_q), 16'd0};
          state_q <= StSum;
        end
        StSum: begin
          idx_q <= dsum[52] ? $signed(node_rd_q[31:16]) : $signed(node_rd_q[15:0]);
          state_q <= StNext;
        end
        StNext: begin
          if (idx_q >= 0) begin
            state_q <= StNodeRd;
          end else begin
            if (idx_q != bhm_pkg::SolidLeaf) cur_q[axis_q] <= tgt_q[axis_q];
            else if (axis_q == 2'd2 && tgt_q[2] < cur_q[2]) ground_q <= 1'b1;
            axis_q <= axis_q + 2'd1;
            state_q <= StAxis;
          end
        end
        StOut: begin
          if (!res_valid_q || res_ready_i) begin
            res_q.pos_x <= cur_q[0];
            res_q.pos_y <= cur_q[1];
            res_q.pos_z <= cur_q[2];
            res_q.on_ground <= ground_q;
            res_q.walk_fault <= fault_q;
            res_valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### src/bhm_checker.sv
// Port-level checker for the axis move block, bound to the top level.
`timescale 1ns / 1ps
`include "bsp_hull_axis_move_assert.svh"
module bhm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         cfg_ready_o
);
  `BHM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BHM_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `BHM_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[103:98] == 6'd0)
  `BHM_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_o)
  `BHM_ASSERT_IMP(a_out_known, m_axis_tvalid, !$isunknown(m_axis_tdata))
endmodule

bind bsp_hull_axis_move bhm_checker u_checker (.*);

### dv/bsp_hull_axis_move_test.sv
// Testbench for the axis move block: directed and random traffic against a predictor.
`timescale 1ns / 1ps
module bsp_hull_axis_move_test;
  localparam int         TreeNodes  = 40;
  localparam int         TreePlanes = 16;
  localparam int         CycleLimit = 400000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] entry;
    logic [11:0] plane_ref;
    logic [15:0] child_neg;
    logic [15:0] child_pos;
    logic [31:0] vec [3];
    logic [31:0] aux [3];
    logic [1:0]  hull;
  } beat_t;

  typedef struct {
    logic [31:0] pos [3];
    logic        on_ground;
    logic        walk_fault;
  } move_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [12:0]  cfg_data_i = '0;

  bsp_hull_axis_move dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor copy of tables and registers
  logic [11:0] node_plane [bhm_pkg::NodeDepth];
  int          node_neg [bhm_pkg::NodeDepth];
  int          node_pos [bhm_pkg::NodeDepth];
  bit          node_written [bhm_pkg::NodeDepth];
  int          plane_normal [bhm_pkg::PlaneDepth][3];
  int          plane_dist [bhm_pkg::PlaneDepth];
  bit          plane_written [bhm_pkg::PlaneDepth];
  int          root_one = -1;
  int          root_two = -1;
  int          node_count = 0;
  int          plane_limit = 0;

  move_result_t expected_moves [$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           steady = 1'b0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bsp_hull_axis_move regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) m_axis_tready <= steady || ($urandom_range(99) >= 23);

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", field, want, got);
  endtask

  always @(posedge clk_i) begin
    move_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_moves.size() == 0) begin
        note_mismatch("unexpected beat", '0, m_axis_tdata[31:0]);
      end else begin
        want = expected_moves.pop_front();
        for (int a = 0; a < 3; a++)
          if (m_axis_tdata[32*a +: 32] !== want.pos[a])
            note_mismatch($sformatf("pos[%0d]", a), want.pos[a], m_axis_tdata[32*a +: 32]);
        if (m_axis_tdata[96] !== want.on_ground)
          note_mismatch("on_ground", want.on_ground, m_axis_tdata[96]);
        if (m_axis_tdata[97] !== want.walk_fault)
          note_mismatch("walk_fault", want.walk_fault, m_axis_tdata[97]);
      end
    end
  end

  function automatic int clamp_normal(logic signed [31:0] v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return int'(v);
  endfunction

  // Walk the tree for one point; unsafe flags a read of an entry never written.
  function automatic bit point_is_solid(longint p [3], int root, inout bit fault,
                                        inout bit unsafe);
    int     idx;
    int     steps;
    int     pl;
    longint d;
    idx = root;
    steps = 0;
    if (root < 0) begin
      fault = 1'b1;
      return 1'b0;
    end
    while (idx >= 0) begin
      steps++;
      if (steps > bhm_pkg::MaxWalkSteps || idx >= node_count
          || idx >= bhm_pkg::NodeDepth) begin
        fault = 1'b1;
        return 1'b0;
      end
      if (!node_written[idx]) unsafe = 1'b1;
      pl = node_plane[idx];
      if (pl >= plane_limit) begin
        fault = 1'b1;
        return 1'b0;
      end
      if (!plane_written[pl]) unsafe = 1'b1;
      if (unsafe) return 1'b0;
      d = longint'(plane_normal[pl][0]) * p[0] + longint'(plane_normal[pl][1]) * p[1]
        + longint'(plane_normal[pl][2]) * p[2] - longint'(plane_dist[pl]) * 65536;
      idx = (d < 0) ? node_neg[idx] : node_pos[idx];
    end
    return idx == int'(bhm_pkg::SolidLeaf);
  endfunction

  function automatic move_result_t predict_move(beat_t b, output bit unsafe);
    move_result_t r;
    longint from [3];
    longint dest [3];
    longint cur [3];
    longint trial [3];
    int     root;
    bit     fault;
    bit     solid;
    fault = 1'b0;
    unsafe = 1'b0;
    r.on_ground = 1'b0;
    root = (b.hull == 2'd2) ? root_two : root_one;
    for (int a = 0; a < 3; a++) begin
      from[a] = longint'($signed(b.vec[a]));
      dest[a] = longint'($signed(b.aux[a]));
      cur[a] = from[a];
    end
    for (int a = 0; a < 3; a++) begin
      if (dest[a] != from[a]) begin
        trial = cur;
        trial[a] = dest[a];
        solid = point_is_solid(trial, root, fault, unsafe);
        if (!solid) cur[a] = dest[a];
        else if (a == 2 && dest[2] < from[2]) r.on_ground = 1'b1;
      end
    end
    for (int a = 0; a < 3; a++) r.pos[a] = cur[a][31:0];
    r.walk_fault = fault;
    return r;
  endfunction

  // Send one beat; moves that would read unwritten entries are dropped unsent.
  task automatic send_beat(beat_t b);
    logic [255:0] d;
    move_result_t want;
    bit           unsafe;
    unsafe = 1'b0;
    if (b.cmd == bhm_pkg::CmdMove) want = predict_move(b, unsafe);
    if (unsafe) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end else begin
      d = '0;
      d[11:0] = b.entry;
      d[23:12] = b.plane_ref;
      d[39:24] = b.child_neg;
      d[55:40] = b.child_pos;
      for (int a = 0; a < 3; a++) begin
        d[56 + 32*a +: 32] = b.vec[a];
        d[152 + 32*a +: 32] = b.aux[a];
      end
      d[249:248] = b.hull;
      if (!steady) begin
        while ($urandom_range(99) < 23) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= d;
      s_axis_tuser <= b.cmd;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      case (b.cmd)
        bhm_pkg::CmdNode: begin
          node_plane[b.entry] = b.plane_ref;
          node_neg[b.entry] = int'($signed(b.child_neg));
          node_pos[b.entry] = int'($signed(b.child_pos));
          node_written[b.entry] = 1'b1;
        end
        bhm_pkg::CmdPlane: begin
          for (int a = 0; a < 3; a++) plane_normal[b.entry][a] = clamp_normal(b.vec[a]);
          plane_dist[b.entry] = int'($signed(b.aux[0]));
          plane_written[b.entry] = 1'b1;
        end
        bhm_pkg::CmdMove: expected_moves.push_back(want);
        default: ;
      endcase
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[12:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      bhm_pkg::CfgHullOne: root_one = int'($signed(value[12:0]));
      bhm_pkg::CfgHullTwo: root_two = int'($signed(value[12:0]));
      bhm_pkg::CfgNodes:   node_count = int'(value[12:0]);
      default:             plane_limit = int'(value[12:0]);
    endcase
  endtask

  task automatic set_regs(int one, int two, int nodes, int planes);
    settle();
    write_reg(bhm_pkg::CfgHullOne, one);
    write_reg(bhm_pkg::CfgHullTwo, two);
    write_reg(bhm_pkg::CfgNodes, nodes);
    write_reg(bhm_pkg::CfgPlanes, planes);
  endtask

  function automatic beat_t node_beat(int entry, int pl, int neg, int pos);
    beat_t b = '{default: '0, vec: '{0, 0, 0}, aux: '{0, 0, 0}};
    b.cmd = bhm_pkg::CmdNode;
    b.entry = entry[11:0];
    b.plane_ref = pl[11:0];
    b.child_neg = neg[15:0];
    b.child_pos = pos[15:0];
    return b;
  endfunction

  function automatic beat_t plane_beat(int entry, int nx, int ny, int nz, int offset);
    beat_t b = '{default: '0, vec: '{0, 0, 0}, aux: '{0, 0, 0}};
    b.cmd = bhm_pkg::CmdPlane;
    b.entry = entry[11:0];
    b.vec = '{nx, ny, nz};
    b.aux[0] = offset;
    return b;
  endfunction

  function automatic beat_t move_beat(int sx, int sy, int sz, int tx, int ty, int tz,
                                      int hull);
    beat_t b = '{default: '0, vec: '{0, 0, 0}, aux: '{0, 0, 0}};
    b.cmd = bhm_pkg::CmdMove;
    b.vec = '{sx, sy, sz};
    b.aux = '{tx, ty, tz};
    b.hull = hull[1:0];
    return b;
  endfunction

  task automatic test_directed();
    beat_t b;
    // missing hull right after reset
    send_beat(move_beat(0, 0, 0, 4096, 0, 0, 1));
    send_beat(plane_beat(0, 0, 0, 65536, 0));
    send_beat(plane_beat(1, 32'h7fffffff, 32'h80000000, 5, 32'h80000000));
    send_beat(plane_beat(4095, 131072, -131073, 1, 32'h7fffffff));
    send_beat(node_beat(0, 0, -2, -1));
    send_beat(node_beat(1, 1, -2, -1));
    send_beat(node_beat(2, 0, 2, 2));
    send_beat(node_beat(4095, 4095, 32'h8000, 32'h7fff));
    b = node_beat(7, 0, -1, -1);
    b.cmd = bhm_pkg::CmdSpare;
    send_beat(b);
    set_regs(0, 2, 3, 2);
    send_beat(move_beat(0, 0, 4096, 0, 0, -4096, 1));   // blocked fall
    send_beat(move_beat(0, 0, -4096, 8, 8, 4096, 0));
    send_beat(move_beat(0, 0, 4096, 99, 0, 4096, 3));
    send_beat(move_beat(5, 6, 7, 5, 6, 7, 1));           // nothing changes
    send_beat(move_beat(0, 0, 0, 0, 0, 12, 2));          // looping tree hits step limit
    set_regs(4095, -1, 4096, 2);
    send_beat(move_beat(0, 0, 0, 1, 0, 0, 1));           // bad plane
    send_beat(move_beat(0, 0, 0, 1, 0, 0, 2));           // no crouching hull
    set_regs(1, 4095, 4096, 4096);
    send_beat(move_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h80000000, 1));
    send_beat(move_beat(-1, -1, -1, 0, 0, 0, 2));
    set_regs(0, 0, 0, 0);
    send_beat(move_beat(0, 0, 0, 1, 1, 1, 1));           // bad node
  endtask

  function automatic int rand_normal();
    if ($urandom_range(9) < 2) return $urandom;
    return $urandom_range(131072) - 65536;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(19) == 0) return $urandom;
    return $urandom_range(1 << 21) - (1 << 20);
  endfunction

  function automatic int tree_child(int i);
    int r = $urandom_range(9);
    if (i >= TreeNodes - 1 || r < 4) return int'(bhm_pkg::SolidLeaf);
    if (r < 6) return ($urandom_range(1)) ? -1 : -int'($urandom_range(32767)) - 1;
    return i + 1 + $urandom_range(TreeNodes - 2 - i);
  endfunction

  function automatic beat_t random_beat();
    int    r = $urandom_range(99);
    int    i;
    int    c [3];
    beat_t b;
    if (r < 70) begin
      for (int a = 0; a < 3; a++) c[a] = rand_coord();
      b = move_beat(c[0], c[1], c[2], c[0], c[1], c[2], $urandom_range(3));
      for (int a = 0; a < 3; a++)
        if ($urandom_range(4) != 0)
          b.aux[a] = ($urandom_range(19) == 0) ? $urandom
                     : c[a] + $urandom_range(1 << 17) - (1 << 16);
    end else if (r < 82) begin
      i = $urandom_range(TreeNodes - 1);
      b = node_beat(i, ($urandom_range(19) == 0) ? $urandom_range(4095)
                       : $urandom_range(TreePlanes - 1), tree_child(i), tree_child(i));
    end else if (r < 90) begin
      b = plane_beat($urandom_range(TreePlanes - 1), rand_normal(), rand_normal(),
                     rand_normal(), rand_coord());
    end else if (r < 95) begin
      // far entries, reachable only through the top root
      if ($urandom_range(1))
        b = node_beat($urandom_range(4095, 2048), $urandom, $urandom, $urandom);
      else
        b = plane_beat($urandom_range(4095, TreePlanes), $urandom, $urandom, $urandom,
                       $urandom);
    end else begin
      b = node_beat($urandom, $urandom, $urandom, $urandom);
      b.cmd = bhm_pkg::CmdSpare;
      b.vec = '{$urandom, $urandom, $urandom};
      b.aux = '{$urandom, $urandom, $urandom};
    end
    return b;
  endfunction

  function automatic int pick_root();
    int r = $urandom_range(9);
    if (r < 6) return 0;
    if (r < 8) return $urandom_range(TreeNodes - 1);
    return (r == 8) ? -1 : 4095;
  endfunction

  function automatic int pick_count(int used);
    int r = $urandom_range(9);
    if (r < 6) return used;
    if (r == 6) return 4096;
    if (r == 7) return 0;
    return $urandom_range(used, 1);
  endfunction

  task automatic test_random_moves();
    int sent = 0;
    for (int i = 0; i < TreePlanes; i++)
      send_beat(plane_beat(i, rand_normal(), rand_normal(), rand_normal(), rand_coord()));
    for (int i = TreeNodes - 1; i >= 0; i--)
      send_beat(node_beat(i, $urandom_range(TreePlanes - 1), tree_child(i), tree_child(i)));
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) set_regs(0, 0, TreeNodes, TreePlanes);
      else set_regs(pick_root(), pick_root(), pick_count(TreeNodes), pick_count(TreePlanes));
      for (int k = 0; k < 130; k++) begin
        steady = (sent >= 300 && sent < 550);
        send_beat(random_beat());
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_moves();
    settle();
    if (mismatches == 0 && expected_moves.size() == 0) begin
      $display("bsp_hull_axis_move regression: pass");
    end else begin
      $display("bsp_hull_axis_move regression: fail");
    end
    $finish;
  end
endmodule
